[rtl/core/owb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_pkg
// Shared types and constants for the single-wire bus master.
// ----------------------------------------------------------------------------
package owb_pkg;

    localparam int CFG_WIDTH         = 10;
    localparam int CFG_ADDR_WIDTH    = 3;
    localparam int BITS_PER_TRANSFER = 8;
    localparam int BIT_CNT_WIDTH     = 4;
    localparam int PRE_RELEASE       = 50;

    // Register indexes
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RESET_LOW      = 3'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_PRES_DELAY     = 3'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_PRES_TIMEOUT   = 3'd2;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_RESET_REC      = 3'd3;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SLOT_LOW       = 3'd4;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SLOT_HOLD      = 3'd5;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_SAMPLE_DELAY   = 3'd6;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_WRITE_REC      = 3'd7;

    // Command codes
    localparam logic [1:0] ACT_RESET = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_PRE   = 4'd1,
        PH_RST_LOW   = 4'd2,
        PH_RST_DELAY = 4'd3,
        PH_RST_POLL  = 4'd4,
        PH_RST_REC   = 4'd5,
        PH_WR_LOW    = 4'd6,
        PH_WR_DRIVE  = 4'd7,
        PH_WR_REC    = 4'd8,
        PH_RD_PRE    = 4'd9,
        PH_RD_LOW    = 4'd10,
        PH_RD_WAIT   = 4'd11,
        PH_RD_TAIL   = 4'd12
    } phase_t;

    typedef struct packed {
        logic [CFG_WIDTH-1:0] reset_low_time;
        logic [CFG_WIDTH-1:0] presence_delay;
        logic [CFG_WIDTH-1:0] presence_timeout;
        logic [CFG_WIDTH-1:0] reset_recovery;
        logic [CFG_WIDTH-1:0] slot_start_low;
        logic [CFG_WIDTH-1:0] slot_hold;
        logic [CFG_WIDTH-1:0] read_sample_delay;
        logic [CFG_WIDTH-1:0] write_recovery;
    } cfg_t;

    localparam cfg_t CFG_DEFAULT = '{
        reset_low_time:    10'd500,
        presence_delay:    10'd40,
        presence_timeout:  10'd500,
        reset_recovery:    10'd500,
        slot_start_low:    10'd5,
        slot_hold:         10'd65,
        read_sample_delay: 10'd5,
        write_recovery:    10'd2
    };

endpackage

[rtl/core/owb_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_cfg
// Timing register bank, write only.
// ----------------------------------------------------------------------------
module owb_cfg import owb_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0]      cfg_wdata,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                CFG_RESET_LOW:    cfg_next.reset_low_time    = cfg_wdata;
                CFG_PRES_DELAY:   cfg_next.presence_delay    = cfg_wdata;
                CFG_PRES_TIMEOUT: cfg_next.presence_timeout  = cfg_wdata;
                CFG_RESET_REC:    cfg_next.reset_recovery    = cfg_wdata;
                CFG_SLOT_LOW:     cfg_next.slot_start_low    = cfg_wdata;
                CFG_SLOT_HOLD:    cfg_next.slot_hold         = cfg_wdata;
                CFG_SAMPLE_DELAY: cfg_next.read_sample_delay = cfg_wdata;
                CFG_WRITE_REC:    cfg_next.write_recovery    = cfg_wdata;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_DEFAULT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/owb_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// owb_step
// Next-state and output logic for one microsecond tick.
// ----------------------------------------------------------------------------
module owb_step import owb_pkg::*; #(
    parameter int TIME_BITS = 10
) (
    input  logic                     start_req,
    input  logic [1:0]               action,
    input  logic [7:0]               write_byte,
    input  logic                     line_level,
    input  cfg_t                     cfg,
    input  phase_t                   phase,
    input  logic [TIME_BITS-1:0]     time_left,
    input  logic [TIME_BITS-1:0]     poll_count,
    input  logic [BIT_CNT_WIDTH-1:0] bits_left,
    input  logic [7:0]               shift_data,
    input  logic                     absent_flag,
    input  logic [7:0]               last_read,
    output phase_t                   phase_next,
    output logic [TIME_BITS-1:0]     time_left_next,
    output logic [TIME_BITS-1:0]     poll_count_next,
    output logic [BIT_CNT_WIDTH-1:0] bits_left_next,
    output logic [7:0]               shift_data_next,
    output logic                     absent_flag_next,
    output logic [7:0]               last_read_next,
    output logic                     pull_low,
    output logic                     busy_res,
    output logic                     done_res
);

    localparam logic [TIME_BITS-1:0] T_ONE = TIME_BITS'(1);
    localparam logic [BIT_CNT_WIDTH-1:0] B_ONE = BIT_CNT_WIDTH'(1);

    logic fin;

    // zero counts as one tick
    function automatic logic [TIME_BITS-1:0] dur(input logic [CFG_WIDTH-1:0] v);
        logic [TIME_BITS-1:0] m;
        m = TIME_BITS'(v);
        return (m == '0) ? T_ONE : m;
    endfunction

    always_comb begin
        phase_next       = phase;
        time_left_next   = time_left;
        poll_count_next  = poll_count;
        bits_left_next   = bits_left;
        shift_data_next  = shift_data;
        absent_flag_next = absent_flag;
        last_read_next   = last_read;
        pull_low         = 1'b0;
        busy_res         = 1'b0;
        done_res         = 1'b0;
        fin              = 1'b0;

        // command launch; this tick is already the first of the command
        if (phase == PH_IDLE && start_req) begin
            case (action)
                ACT_RESET: begin
                    phase_next     = PH_RST_PRE;
                    time_left_next = TIME_BITS'(PRE_RELEASE);
                end
                ACT_WRITE: begin
                    bits_left_next  = BIT_CNT_WIDTH'(BITS_PER_TRANSFER);
                    shift_data_next = write_byte;
                    phase_next      = PH_WR_LOW;
                    time_left_next  = dur(cfg.slot_start_low);
                end
                ACT_READ: begin
                    bits_left_next  = BIT_CNT_WIDTH'(BITS_PER_TRANSFER);
                    shift_data_next = 8'h00;
                    phase_next      = PH_RD_PRE;
                    time_left_next  = dur(cfg.read_sample_delay);
                end
                default: begin
                    phase_next = phase;
                end
            endcase
        end

        if (phase_next != PH_IDLE) begin
            busy_res = 1'b1;
            if (phase_next == PH_RST_LOW || phase_next == PH_WR_LOW
                    || phase_next == PH_RD_LOW) begin
                pull_low = 1'b1;
            end else if (phase_next == PH_WR_DRIVE) begin
                pull_low = ~shift_data_next[0];
            end

            if (phase_next == PH_RST_POLL) begin
                if (!line_level) begin
                    absent_flag_next = 1'b0;
                    phase_next       = PH_RST_REC;
                    time_left_next   = dur(cfg.reset_recovery);
                end else begin
                    poll_count_next = poll_count + T_ONE;
                    if (poll_count_next >= dur(cfg.presence_timeout)) begin
                        absent_flag_next = 1'b1;
                        phase_next       = PH_RST_REC;
                        time_left_next   = dur(cfg.reset_recovery);
                    end
                end
            end else begin
                // sample on the last tick of the release
                if (phase_next == PH_RD_WAIT && time_left_next <= T_ONE) begin
                    shift_data_next = {line_level, shift_data_next[7:1]};
                end
                if (time_left_next != '0) begin
                    time_left_next = time_left_next - T_ONE;
                end
                if (time_left_next == '0) begin
                    case (phase_next)
                        PH_RST_PRE: begin
                            phase_next     = PH_RST_LOW;
                            time_left_next = dur(cfg.reset_low_time);
                        end
                        PH_RST_LOW: begin
                            phase_next     = PH_RST_DELAY;
                            time_left_next = dur(cfg.presence_delay);
                        end
                        PH_RST_DELAY: begin
                            phase_next      = PH_RST_POLL;
                            poll_count_next = '0;
                        end
                        PH_WR_LOW: begin
                            phase_next     = PH_WR_DRIVE;
                            time_left_next = dur(cfg.slot_hold);
                        end
                        PH_WR_DRIVE: begin
                            if (TIME_BITS'(cfg.write_recovery) != '0) begin
                                phase_next     = PH_WR_REC;
                                time_left_next = TIME_BITS'(cfg.write_recovery);
                            end else begin
                                // no recovery gap: close the bit now
                                shift_data_next = {1'b0, shift_data_next[7:1]};
                                bits_left_next  = bits_left_next - B_ONE;
                                if (bits_left_next == '0) begin
                                    fin = 1'b1;
                                end else begin
                                    phase_next     = PH_WR_LOW;
                                    time_left_next = dur(cfg.slot_start_low);
                                end
                            end
                        end
                        PH_WR_REC: begin
                            shift_data_next = {1'b0, shift_data_next[7:1]};
                            bits_left_next  = bits_left_next - B_ONE;
                            if (bits_left_next == '0) begin
                                fin = 1'b1;
                            end else begin
                                phase_next     = PH_WR_LOW;
                                time_left_next = dur(cfg.slot_start_low);
                            end
                        end
                        PH_RD_PRE: begin
                            phase_next     = PH_RD_LOW;
                            time_left_next = dur(cfg.slot_start_low);
                        end
                        PH_RD_LOW: begin
                            phase_next     = PH_RD_WAIT;
                            time_left_next = dur(cfg.read_sample_delay);
                        end
                        PH_RD_WAIT: begin
                            phase_next     = PH_RD_TAIL;
                            time_left_next = dur(cfg.slot_hold);
                        end
                        PH_RD_TAIL: begin
                            bits_left_next = bits_left_next - B_ONE;
                            if (bits_left_next == '0) begin
                                last_read_next = shift_data_next;
                                fin            = 1'b1;
                            end else begin
                                phase_next     = PH_RD_LOW;
                                time_left_next = dur(cfg.slot_start_low);
                            end
                        end
                        default: begin
                            fin = 1'b1;  // end of reset recovery
                        end
                    endcase
                end
            end

            if (fin) begin
                phase_next     = PH_IDLE;
                time_left_next = '0;
                done_res       = 1'b1;
            end
        end
    end

endmodule

[rtl/core/one_wire_bus_master.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Single-wire bus master stepped by one-microsecond tick words.
// ----------------------------------------------------------------------------
// Usage:
//  - s_ channel: one word per microsecond tick carrying start_req, action,
//    write_byte and the sampled line_level. A start is honoured only when idle.
//  - m_ channel: exactly one result word per tick word: pull_low (open-drain
//    drive), busy_res, done_res, no_presence and the last read_byte.
//  - cfg_ port: eight 10-bit timing registers; write only while idle, unenforced.
//  - Results are registered and appear in the cycle after the tick is taken.
//  - Throughput: one word per cycle; the tick state step is a single pass of
//    counter decrement, compare and phase select between the state registers.
//  - The result register frees itself in the cycle it is taken, so a new
//    tick is accepted while the previous result is being taken.
//  - If the receiver stalls with a result pending, s_ready drops and the
//    bus state does not advance until the result is taken.
//  - Synchronous reset returns the master to idle, clears flags and the read
//    byte, and restores the default timings.
// ----------------------------------------------------------------------------
module one_wire_bus_master import owb_pkg::*; #(
    parameter int TIME_BITS = 10
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration
    input  logic                      cfg_we,
    input  logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [CFG_WIDTH-1:0]      cfg_wdata,

    // tick words in
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic                      s_start_req,
    input  logic [1:0]                s_action,
    input  logic [7:0]                s_write_byte,
    input  logic                      s_line_level,

    // result words out
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_pull_low,
    output logic                      m_busy_res,
    output logic                      m_done_res,
    output logic                      m_no_presence,
    output logic [7:0]                m_read_byte
);

    cfg_t cfg;

    // bus sequencer state
    phase_t                   phase_reg;
    logic [TIME_BITS-1:0]     time_left_reg;
    logic [TIME_BITS-1:0]     poll_count_reg;
    logic [BIT_CNT_WIDTH-1:0] bits_left_reg;
    logic [7:0]               shift_data_reg;
    logic                     absent_flag_reg;
    logic [7:0]               last_read_reg;

    phase_t                   phase_next;
    logic [TIME_BITS-1:0]     time_left_next;
    logic [TIME_BITS-1:0]     poll_count_next;
    logic [BIT_CNT_WIDTH-1:0] bits_left_next;
    logic [7:0]               shift_data_next;
    logic                     absent_flag_next;
    logic [7:0]               last_read_next;

    logic step_pull;
    logic step_busy;
    logic step_done;

    // result register
    logic       m_valid_reg;
    logic       pull_low_reg;
    logic       busy_res_reg;
    logic       done_res_reg;
    logic       no_presence_reg;
    logic [7:0] read_byte_reg;

    logic s_fire;

    owb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owb_step #(
        .TIME_BITS (TIME_BITS)
    ) u_step (
        .start_req        (s_start_req),
        .action           (s_action),
        .write_byte       (s_write_byte),
        .line_level       (s_line_level),
        .cfg              (cfg),
        .phase            (phase_reg),
        .time_left        (time_left_reg),
        .poll_count       (poll_count_reg),
        .bits_left        (bits_left_reg),
        .shift_data       (shift_data_reg),
        .absent_flag      (absent_flag_reg),
        .last_read        (last_read_reg),
        .phase_next       (phase_next),
        .time_left_next   (time_left_next),
        .poll_count_next  (poll_count_next),
        .bits_left_next   (bits_left_next),
        .shift_data_next  (shift_data_next),
        .absent_flag_next (absent_flag_next),
        .last_read_next   (last_read_next),
        .pull_low         (step_pull),
        .busy_res         (step_busy),
        .done_res         (step_done)
    );

    // take a word when the result slot is empty or being emptied
    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;

    // state only moves on an accepted tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            time_left_reg   <= '0;
            poll_count_reg  <= '0;
            bits_left_reg   <= '0;
            shift_data_reg  <= '0;
            absent_flag_reg <= 1'b0;
            last_read_reg   <= '0;
        end else if (s_fire) begin
            phase_reg       <= phase_next;
            time_left_reg   <= time_left_next;
            poll_count_reg  <= poll_count_next;
            bits_left_reg   <= bits_left_next;
            shift_data_reg  <= shift_data_next;
            absent_flag_reg <= absent_flag_next;
            last_read_reg   <= last_read_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            pull_low_reg    <= step_pull;
            busy_res_reg    <= step_busy;
            done_res_reg    <= step_done;
            no_presence_reg <= absent_flag_next;
            read_byte_reg   <= last_read_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_pull_low    = pull_low_reg;
    assign m_busy_res    = busy_res_reg;
    assign m_done_res    = done_res_reg;
    assign m_no_presence = no_presence_reg;
    assign m_read_byte   = read_byte_reg;

`ifndef SYNTH
    // idle sequencer always has a cleared timer
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> time_left_reg == '0)
        else $error("idle phase with running timer");

    // a finishing tick leaves the sequencer idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && step_done |=> phase_reg == PH_IDLE)
        else $error("command finished but sequencer not idle");

    // bus is only driven during a command
    a_pull_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pull_low |-> m_busy_res)
        else $error("line pulled low outside a command");

    // completion is flagged only on a busy tick
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done reported on idle tick");

    // bit counter stays within one byte
    a_bit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bits_left_reg <= BIT_CNT_WIDTH'(BITS_PER_TRANSFER))
        else $error("bit counter out of range");
`endif

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the single-wire bus master. The bench streams tick
// words into the master and compares every result word it returns against an
// in-bench model of the bus sequencer.
// ----------------------------------------------------------------------------
// - Commands are queued as whole sequences: a start tick followed by enough
//   plain ticks to carry the command to its end, with the sampled line level
//   shaped to give presence, no presence, all-zero and all-one reads.
// - The model steps once per accepted tick word; its outputs are queued and
//   each returned word is compared field by field with the oldest one.
// - Timing registers are rewritten only once the model is idle and every
//   result word has been taken; the run covers all ones (no write recovery),
//   all zeros, several short random sets and finally a short fixed set.
// - Both sides stall in random bursts; the final phase runs without stalls.
// ----------------------------------------------------------------------------
module testbench;
    import owb_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 10;
    localparam int RANDOM_PHASES = 4;
    localparam int RANDOM_TICKS_PER_PHASE = 50;

    // action code that the master must ignore
    localparam logic [1:0] ACT_NONE = 2'd3;

    // how the sampled line level is shaped over a command
    localparam int LINE_HIGH   = 0;  // never low: no presence, reads give ones
    localparam int LINE_LOW    = 1;  // always low: instant presence, reads give zeros
    localparam int LINE_RANDOM = 2;
    localparam int LINE_SPARSE = 3;  // mostly high, the odd low tick

    typedef struct {
        bit         start_req;
        logic [1:0] action;
        logic [7:0] write_byte;
        bit         line_level;
        bit         hold_off;     // wait for the result queue to drain before sending
    } tick_word_t;

    typedef struct {
        bit         pull_low;
        bit         busy_res;
        bit         done_res;
        bit         no_presence;
        logic [7:0] read_byte;
    } bus_word_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------------
    logic aclk = 1'b0;
    logic aresetn;

    logic                      cfg_we;
    logic [CFG_ADDR_WIDTH-1:0] cfg_addr;
    logic [CFG_WIDTH-1:0]      cfg_wdata;

    logic       s_valid      = 1'b0;
    logic       s_ready;
    logic       s_start_req  = 1'b0;
    logic [1:0] s_action     = '0;
    logic [7:0] s_write_byte = '0;
    logic       s_line_level = 1'b1;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_pull_low;
    logic       m_busy_res;
    logic       m_done_res;
    logic       m_no_presence;
    logic [7:0] m_read_byte;

    always #5 aclk = ~aclk;

    one_wire_bus_master DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_start_req   (s_start_req),
        .s_action      (s_action),
        .s_write_byte  (s_write_byte),
        .s_line_level  (s_line_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_pull_low    (m_pull_low),
        .m_busy_res    (m_busy_res),
        .m_done_res    (m_done_res),
        .m_no_presence (m_no_presence),
        .m_read_byte   (m_read_byte)
    );

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    tick_word_t pending_ticks[$];
    bus_word_t  expected_bus_outputs[$];
    tick_word_t tick_on_bus;
    bus_word_t  predicted_word;
    bus_word_t  wanted_word;

    // tick, result and cycle counters read across processes are updated with
    // NBAs only, so a reader at the clock edge always sees the pre-edge count
    int ticks_taken   = 0;
    int results_taken = 0;
    int ticks_queued  = 0;   // written by the stimulus process alone
    int mismatches    = 0;
    int cycle_count   = 0;

    int src_gap_odds  = 0;   // 1-in-N chance of a stall burst, 0 for none
    int sink_gap_odds = 0;
    int src_gap       = 0;
    int sink_gap      = 0;

    // ------------------------------------------------------------------------
    // Bus sequencer model: timing registers and sequencer state
    // ------------------------------------------------------------------------
    logic [CFG_WIDTH-1:0] timing [8];
    logic [CFG_WIDTH-1:0] next_timing [8];

    phase_t               bus_phase;
    logic [CFG_WIDTH-1:0] bus_time_left;
    logic [CFG_WIDTH-1:0] bus_polls;
    logic [3:0]           bus_bits_left;
    logic [7:0]           bus_shift;
    bit                   bus_absent;
    logic [7:0]           bus_last_read;

    // a zero duration still lasts one tick
    function automatic int phase_span(logic [CFG_ADDR_WIDTH-1:0] idx);
        return (timing[idx] == '0) ? 1 : int'(timing[idx]);
    endfunction

    function automatic void load_phase(phase_t p, int ticks);
        bus_phase     = p;
        bus_time_left = CFG_WIDTH'(ticks);
        if (bus_time_left == '0) begin
            bus_time_left = CFG_WIDTH'(1);
        end
    endfunction

    // Step to the next phase once the current one has run out; 1 on command end.
    function automatic bit next_phase();
        case (bus_phase)
            PH_RST_PRE:   load_phase(PH_RST_LOW, phase_span(CFG_RESET_LOW));
            PH_RST_LOW:   load_phase(PH_RST_DELAY, phase_span(CFG_PRES_DELAY));
            PH_RST_DELAY: begin
                bus_phase = PH_RST_POLL;
                bus_polls = '0;
            end
            PH_WR_LOW:    load_phase(PH_WR_DRIVE, phase_span(CFG_SLOT_HOLD));
            PH_WR_DRIVE, PH_WR_REC: begin
                // a zero write recovery drops the recovery phase altogether
                if (bus_phase == PH_WR_DRIVE && timing[CFG_WRITE_REC] != '0) begin
                    load_phase(PH_WR_REC, int'(timing[CFG_WRITE_REC]));
                end else begin
                    bus_shift     = bus_shift >> 1;
                    bus_bits_left = bus_bits_left - 4'd1;
                    if (bus_bits_left == '0) begin
                        return 1'b1;
                    end
                    load_phase(PH_WR_LOW, phase_span(CFG_SLOT_LOW));
                end
            end
            PH_RD_PRE:    load_phase(PH_RD_LOW, phase_span(CFG_SLOT_LOW));
            PH_RD_LOW:    load_phase(PH_RD_WAIT, phase_span(CFG_SAMPLE_DELAY));
            PH_RD_WAIT:   load_phase(PH_RD_TAIL, phase_span(CFG_SLOT_HOLD));
            PH_RD_TAIL: begin
                bus_bits_left = bus_bits_left - 4'd1;
                if (bus_bits_left == '0) begin
                    bus_last_read = bus_shift;
                    return 1'b1;
                end
                load_phase(PH_RD_LOW, phase_span(CFG_SLOT_LOW));
            end
            default: return 1'b1;
        endcase
        return 1'b0;
    endfunction

    function automatic void bus_master_step(input tick_word_t w, output bus_word_t r);
        bit fin;
        fin = 1'b0;
        r   = '{default: '0};

        // a start is honoured only from idle; code 3 leaves it idle
        if (bus_phase == PH_IDLE && w.start_req) begin
            case (w.action)
                ACT_RESET: load_phase(PH_RST_PRE, PRE_RELEASE);
                ACT_WRITE: begin
                    bus_bits_left = 4'(BITS_PER_TRANSFER);
                    bus_shift     = w.write_byte;
                    load_phase(PH_WR_LOW, phase_span(CFG_SLOT_LOW));
                end
                ACT_READ: begin
                    bus_bits_left = 4'(BITS_PER_TRANSFER);
                    bus_shift     = '0;
                    load_phase(PH_RD_PRE, phase_span(CFG_SAMPLE_DELAY));
                end
                default: ;
            endcase
        end

        if (bus_phase != PH_IDLE) begin
            r.busy_res = 1'b1;
            if (bus_phase == PH_RST_LOW || bus_phase == PH_WR_LOW || bus_phase == PH_RD_LOW) begin
                r.pull_low = 1'b1;
            end else if (bus_phase == PH_WR_DRIVE) begin
                r.pull_low = ~bus_shift[0];
            end

            if (bus_phase == PH_RST_POLL) begin
                // first low level means a device answered
                if (!w.line_level) begin
                    bus_absent = 1'b0;
                    load_phase(PH_RST_REC, phase_span(CFG_RESET_REC));
                end else begin
                    bus_polls = bus_polls + CFG_WIDTH'(1);
                    if (int'(bus_polls) >= phase_span(CFG_PRES_TIMEOUT)) begin
                        bus_absent = 1'b1;
                        load_phase(PH_RST_REC, phase_span(CFG_RESET_REC));
                    end
                end
            end else begin
                // read bit is sampled on the last tick of the release
                if (bus_phase == PH_RD_WAIT && bus_time_left <= 1) begin
                    bus_shift = {w.line_level, bus_shift[7:1]};
                end
                if (bus_time_left > 0) begin
                    bus_time_left = bus_time_left - CFG_WIDTH'(1);
                end
                if (bus_time_left == '0) begin
                    fin = next_phase();
                end
            end

            if (fin) begin
                bus_phase     = PH_IDLE;
                bus_time_left = '0;
                r.done_res    = 1'b1;
            end
        end

        r.no_presence = bus_absent;
        r.read_byte   = bus_last_read;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Rough length of a command under the current timings (polls assumed to
    // run to timeout), used to size the plain ticks behind each start.
    function automatic int command_ticks(logic [1:0] act);
        case (act)
            ACT_RESET: return PRE_RELEASE + phase_span(CFG_RESET_LOW)
                              + phase_span(CFG_PRES_DELAY) + phase_span(CFG_PRES_TIMEOUT)
                              + phase_span(CFG_RESET_REC);
            ACT_WRITE: return BITS_PER_TRANSFER * (phase_span(CFG_SLOT_LOW)
                              + phase_span(CFG_SLOT_HOLD) + int'(timing[CFG_WRITE_REC]));
            ACT_READ:  return phase_span(CFG_SAMPLE_DELAY) + BITS_PER_TRANSFER
                              * (phase_span(CFG_SLOT_LOW) + phase_span(CFG_SAMPLE_DELAY)
                              + phase_span(CFG_SLOT_HOLD));
            default:   return 1;
        endcase
    endfunction

    function automatic bit line_for(int mode);
        case (mode)
            LINE_HIGH:   return 1'b1;
            LINE_LOW:    return 1'b0;
            LINE_SPARSE: return $urandom_range(11, 0) != 0;
            default:     return 1'($urandom);
        endcase
    endfunction

    function automatic int pick_odds();
        case ($urandom_range(2, 0))
            0:       return 0;
            1:       return 4;
            default: return 16;
        endcase
    endfunction

    // Start tick plus plain ticks; slack trims or pads the estimate, and a
    // poke drops a second start somewhere in the body while busy.
    task automatic queue_command(input logic [1:0] act, input logic [7:0] data,
                                 input int line_mode, input int slack,
                                 input bit poke_busy, input bit hold_off);
        tick_word_t w;
        int n;
        int poke_at;
        n = command_ticks(act) + slack;
        if (n < 1) begin
            n = 1;
        end
        poke_at = (n > 1) ? $urandom_range(n - 1, 1) : 0;
        for (int i = 0; i < n; i++) begin
            w.start_req  = (i == 0) || (poke_busy && i == poke_at);
            w.action     = (i == 0) ? act : 2'($urandom);
            w.write_byte = (i == 0) ? data : 8'($urandom);
            w.line_level = line_for(line_mode);
            w.hold_off   = (i == 0) && hold_off;
            pending_ticks.push_back(w);
        end
        ticks_queued += n;
    endtask

    task automatic queue_plain_ticks(input int n);
        tick_word_t w;
        for (int i = 0; i < n; i++) begin
            w.start_req  = 1'b0;
            w.action     = 2'($urandom);
            w.write_byte = 8'($urandom);
            w.line_level = 1'($urandom);
            w.hold_off   = 1'b0;
            pending_ticks.push_back(w);
        end
        ticks_queued += n;
    endtask

    // Wait until every queued tick has its result taken and the model sits
    // idle; a command still running gets more plain ticks.
    task automatic wait_until_idle();
        bit settled;
        settled = 1'b0;
        while (!settled) begin
            @(posedge aclk);
            if (results_taken >= ticks_queued) begin
                if (bus_phase == PH_IDLE) begin
                    settled = 1'b1;
                end else begin
                    @(negedge aclk);
                    queue_plain_ticks(64);
                end
            end
        end
    endtask

    // Write all eight registers from next_timing; master must be idle.
    task automatic load_timings();
        for (int i = 0; i < 8; i++) begin
            @(posedge aclk);
            cfg_we    <= 1'b1;
            cfg_addr  <= CFG_ADDR_WIDTH'(i);
            cfg_wdata <= next_timing[i];
            timing[i]  = next_timing[i];
        end
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all_timings(input logic [CFG_WIDTH-1:0] v);
        for (int i = 0; i < 8; i++) begin
            next_timing[i] = v;
        end
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents queued tick words, runs the model on acceptance
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            src_gap  = 0;
        end else begin
            if (s_valid && s_ready) begin
                bus_master_step(tick_on_bus, predicted_word);
                expected_bus_outputs.push_back(predicted_word);
                ticks_taken <= ticks_taken + 1;
            end
            if (!s_valid || s_ready) begin
                if (src_gap > 0) begin
                    src_gap--;
                    s_valid <= 1'b0;
                end else if (src_gap_odds != 0 && $urandom_range(src_gap_odds - 1, 0) == 0) begin
                    src_gap  = $urandom_range(18, 0);
                    s_valid <= 1'b0;
                end else if (pending_ticks.size() != 0 && (!pending_ticks[0].hold_off
                             || (ticks_taken == results_taken && !(s_valid && s_ready)))) begin
                    tick_on_bus   = pending_ticks.pop_front();
                    s_valid      <= 1'b1;
                    s_start_req  <= tick_on_bus.start_req;
                    s_action     <= tick_on_bus.action;
                    s_write_byte <= tick_on_bus.write_byte;
                    s_line_level <= tick_on_bus.line_level;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: random stall bursts on m_ready
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            sink_gap = 0;
        end else if (sink_gap > 0) begin
            sink_gap--;
            m_ready <= 1'b0;
        end else if (sink_gap_odds != 0 && $urandom_range(sink_gap_odds - 1, 0) == 0) begin
            sink_gap = $urandom_range(18, 0);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: each taken result word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_taken <= results_taken + 1;
            if (expected_bus_outputs.size() == 0) begin
                $error("result word taken with nothing expected");
                mismatches++;
            end else begin
                wanted_word = expected_bus_outputs.pop_front();
                if (m_pull_low !== wanted_word.pull_low) begin
                    $error("pull_low: expected %0d, actual %0d", wanted_word.pull_low, m_pull_low);
                    mismatches++;
                end
                if (m_busy_res !== wanted_word.busy_res) begin
                    $error("busy_res: expected %0d, actual %0d", wanted_word.busy_res, m_busy_res);
                    mismatches++;
                end
                if (m_done_res !== wanted_word.done_res) begin
                    $error("done_res: expected %0d, actual %0d", wanted_word.done_res, m_done_res);
                    mismatches++;
                end
                if (m_no_presence !== wanted_word.no_presence) begin
                    $error("no_presence: expected %0d, actual %0d",
                           wanted_word.no_presence, m_no_presence);
                    mismatches++;
                end
                if (m_read_byte !== wanted_word.read_byte) begin
                    $error("read_byte: expected 0x%02h, actual 0x%02h",
                           wanted_word.read_byte, m_read_byte);
                    mismatches++;
                end
            end
        end
    end

    // Backstop against a hung handshake
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial begin
        int pick;
        int target;
        int cmds;
        bit poke;
        bit hold;

        // model starts from the reset timings and an idle sequencer
        timing[CFG_RESET_LOW]    = CFG_DEFAULT.reset_low_time;
        timing[CFG_PRES_DELAY]   = CFG_DEFAULT.presence_delay;
        timing[CFG_PRES_TIMEOUT] = CFG_DEFAULT.presence_timeout;
        timing[CFG_RESET_REC]    = CFG_DEFAULT.reset_recovery;
        timing[CFG_SLOT_LOW]     = CFG_DEFAULT.slot_start_low;
        timing[CFG_SLOT_HOLD]    = CFG_DEFAULT.slot_hold;
        timing[CFG_SAMPLE_DELAY] = CFG_DEFAULT.read_sample_delay;
        timing[CFG_WRITE_REC]    = CFG_DEFAULT.write_recovery;
        bus_phase     = PH_IDLE;
        bus_time_left = '0;
        bus_polls     = '0;
        bus_bits_left = '0;
        bus_shift     = '0;
        bus_absent    = 1'b0;
        bus_last_read = '0;

        cfg_we    = 1'b0;
        cfg_addr  = '0;
        cfg_wdata = '0;
        aresetn   = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Shortest slots and no write recovery: corner cases
        set_all_timings(10'd1);
        next_timing[CFG_WRITE_REC] = '0;
        load_timings();
        @(negedge aclk);
        src_gap_odds  = 4;
        sink_gap_odds = 4;
        queue_command(ACT_NONE, 8'hFF, LINE_RANDOM, 3, 1'b0, 1'b0);
        queue_command(ACT_WRITE, 8'h00, LINE_RANDOM, 1, 1'b0, 1'b0);
        queue_command(ACT_WRITE, 8'hFF, LINE_RANDOM, 1, 1'b1, 1'b0);
        queue_command(ACT_READ, 8'h00, LINE_LOW, 1, 1'b0, 1'b1);
        queue_command(ACT_READ, 8'h00, LINE_HIGH, 1, 1'b1, 1'b0);
        queue_command(ACT_RESET, 8'h00, LINE_LOW, 0, 1'b0, 1'b0);
        queue_command(ACT_RESET, 8'h00, LINE_HIGH, 2, 1'b1, 1'b0);
        queue_command(ACT_READ, 8'h00, LINE_SPARSE, 1, 1'b0, 1'b0);
        wait_until_idle();

        // Every register zero: durations and timeout fall back to one tick, write recovery is dropped
        set_all_timings('0);
        load_timings();
        @(negedge aclk);
        src_gap_odds  = 0;
        sink_gap_odds = 16;
        queue_command(ACT_RESET, 8'h00, LINE_HIGH, 1, 1'b0, 1'b0);
        queue_command(ACT_WRITE, 8'hA5, LINE_RANDOM, 1, 1'b0, 1'b0);
        queue_command(ACT_READ, 8'h00, LINE_RANDOM, 1, 1'b0, 1'b0);
        wait_until_idle();

        // Random short timings, random command streams
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            next_timing[CFG_RESET_LOW]    = CFG_WIDTH'($urandom_range(6, 0));
            next_timing[CFG_PRES_DELAY]   = CFG_WIDTH'($urandom_range(4, 0));
            next_timing[CFG_PRES_TIMEOUT] = CFG_WIDTH'($urandom_range(10, 0));
            next_timing[CFG_RESET_REC]    = CFG_WIDTH'($urandom_range(4, 0));
            next_timing[CFG_SLOT_LOW]     = CFG_WIDTH'($urandom_range(3, 0));
            next_timing[CFG_SLOT_HOLD]    = CFG_WIDTH'($urandom_range(4, 0));
            next_timing[CFG_SAMPLE_DELAY] = CFG_WIDTH'($urandom_range(3, 0));
            next_timing[CFG_WRITE_REC]    = CFG_WIDTH'($urandom_range(3, 0));
            load_timings();
            @(negedge aclk);
            src_gap_odds  = pick_odds();
            sink_gap_odds = pick_odds();
            target = ticks_queued + RANDOM_TICKS_PER_PHASE;
            cmds   = 0;
            while (ticks_queued < target) begin
                pick = $urandom_range(99, 0);
                poke = $urandom_range(3, 0) == 0;
                hold = (cmds == 1) || ($urandom_range(9, 0) == 0);
                if (pick < 22) begin
                    queue_command(ACT_RESET, 8'($urandom), $urandom_range(3, 0),
                                  $urandom_range(4, 0), poke, hold);
                end else if (pick < 52) begin
                    queue_command(ACT_WRITE, 8'($urandom), LINE_RANDOM,
                                  $urandom_range(4, 0), poke, hold);
                end else if (pick < 82) begin
                    queue_command(ACT_READ, 8'($urandom), $urandom_range(3, 0),
                                  $urandom_range(4, 0), poke, hold);
                end else if (pick < 87) begin
                    queue_command(ACT_NONE, 8'($urandom), LINE_RANDOM,
                                  $urandom_range(2, 0), 1'b0, hold);
                end else if (pick < 93) begin
                    queue_plain_ticks($urandom_range(6, 1));
                end else begin
                    // cut short: the next start lands while still busy
                    pick = $urandom_range(2, 0);
                    queue_command(2'(pick), 8'($urandom), LINE_RANDOM,
                                  -(command_ticks(2'(pick)) / 2), 1'b0, hold);
                end
                cmds++;
            end
            wait_until_idle();
        end

        // Short fixed timings, no stalls from here on
        set_all_timings(10'd3);
        next_timing[CFG_WRITE_REC] = 10'd1;
        load_timings();
        @(negedge aclk);
        src_gap_odds  = 0;
        sink_gap_odds = 0;
        queue_command(ACT_RESET, 8'h00, LINE_SPARSE, 2, 1'b0, 1'b0);
        queue_command(ACT_WRITE, 8'($urandom), LINE_RANDOM, 2, 1'b0, 1'b0);
        queue_command(ACT_READ, 8'h00, LINE_RANDOM, 2, 1'b0, 1'b0);
        wait_until_idle();

        // let any stray word surface before the verdict
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_bus_outputs.size() != 0) begin
            $error("%0d result words never arrived", expected_bus_outputs.size());
            mismatches++;
        end
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
